// File: hw/rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the binary max-heap priority queue: command
// and status codes, field widths and the beat layout of both streams.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// Beat field widths
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CMP_W    = 12;
	localparam int unsigned SWP_W    = 11;
	localparam int unsigned CNT_W    = 11;

	// Result beat layout in m_axis_tdata, lowest bit up
	localparam int unsigned RES_LO  = 0;
	localparam int unsigned CMP_LO  = RES_LO + VALUE_W;
	localparam int unsigned SWP_LO  = CMP_LO + CMP_W;
	localparam int unsigned CNT_LO  = SWP_LO + SWP_W;
	localparam int unsigned OUT_USED_W = CNT_LO + CNT_W;
	localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// Saturation limits of the tallies
	localparam logic [CMP_W-1:0] CMP_MAX = '1;
	localparam logic [SWP_W-1:0] SWP_MAX = '1;

	// Commands
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_APPEND = 2'd2,
		CMD_BUILD  = 2'd3
	} cmd_t;

	// Result status
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_UP_RD    = 9'b000000010,
		S_UP_CMP   = 9'b000000100,
		S_DEL_RD   = 9'b000001000,
		S_BLD_NEXT = 9'b000010000,
		S_BLD_RD   = 9'b000100000,
		S_DN_RD    = 9'b001000000,
		S_DN_CMP   = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

endpackage

// File: hw/rtl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit values in a single on-chip store, run by a
// small sequencer around one shared compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   Command beats enter on s_axis (tuser = command, tdata = value). Every
//   command yields exactly one result beat on m_axis. s_axis_tready is high
//   only while the sequencer is idle, so one command is in flight at a time.
// Sequencing (accept to result valid):
//   append, refused insert/append, delete on empty, trivial build: straight to S_DONE
//   insert: S_UP_RD then S_UP_CMP per level, until the value climbs to the root
//           or a parent compare stops it
//   delete: S_DEL_RD, then S_DN_RD and S_DN_CMP per sift level visited
//   build:  S_BLD_NEXT, S_BLD_RD and a sift-down for each of count/2 roots
// Each sift level is a store read step (S_DN_RD) and then a compare/write
// step (S_DN_CMP) on the two-read, one-write store.
// Reset clears the entry count and all control; the store is not cleared and
// needs no clearing pass, since only entries below the count are used.
// A stalled result beat holds in the output register; the sequencer waits
// in its final state until that register is free.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
	parameter int unsigned HEAP_DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command beat: tdata = value[31:0]
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [mhpq_pkg::VALUE_W-1:0]    s_axis_tdata,
	// tuser = command[1:0]
	input  logic [mhpq_pkg::CMD_W-1:0]      s_axis_tuser,
	// result beat: tdata = result_value[31:0], comparisons[43:32],
	// swaps[54:44], entry_count_out[65:55], zero[71:66]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [mhpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// tuser = status[1:0]
	output logic [mhpq_pkg::STATUS_W-1:0]   m_axis_tuser
);
	import mhpq_pkg::*;

	localparam int unsigned IW = $clog2(HEAP_DEPTH);
	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
	localparam int unsigned LW = IW + 2;

	// Heap store
	logic signed [VALUE_W-1:0] mem [HEAP_DEPTH];
	logic signed [VALUE_W-1:0] rd_a_q, rd_b_q;
	logic                      we;
	logic [IW-1:0]             wa, ra, rb;
	logic signed [VALUE_W-1:0] wd;

	// Control and working registers
	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic [IW-1:0]             i_q, k_q;
	logic                      del_mode_q;
	logic signed [VALUE_W-1:0] cur_q, res_q;
	status_t                   status_q;
	logic [CMP_W-1:0]          cmp_q;
	logic [SWP_W-1:0]          swp_q;

	// Output register
	logic                      out_valid_q;
	logic [OUT_DATA_W-1:0]     out_data_q;
	status_t                   out_status_q;

	// Derived indices
	logic                      accept, full, out_free;
	cmd_t                      cmd;
	logic [IW-1:0]             parent, cnt_idx, big_idx;
	logic [LW-1:0]             l_w, r_w, n_w;
	logic [CW:0]               half_cnt;
	logic [CW+CNT_W-1:0]       cnt_ext;
	logic                      l_mv, r_mv, moved;
	logic signed [VALUE_W-1:0] bigv1, big_val;
	logic [1:0]                cmp_inc;
	logic [CMP_W:0]            cmp_sum;
	logic [CMP_W-1:0]          cmp_next;
	logic [SWP_W-1:0]          swp_next;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign cmd      = cmd_t'(s_axis_tuser);
	assign full     = (count_q == CW'(HEAP_DEPTH));
	assign cnt_idx  = count_q[IW-1:0];
	assign half_cnt = {1'b0, count_q} >> 1;
	assign parent   = (i_q - IW'(1)) >> 1;
	assign l_w      = LW'({i_q, 1'b1});
	assign r_w      = LW'({i_q, 1'b1}) + LW'(1);
	assign n_w      = LW'(count_q);
	assign out_free = !out_valid_q || m_axis_tready;
	assign cnt_ext  = {{CNT_W{1'b0}}, count_q};

	// Shared compare unit: pick the largest of hole value and two children
	always_comb begin
		l_mv    = (l_w < n_w) && (rd_a_q > cur_q);
		bigv1   = l_mv ? rd_a_q : cur_q;
		r_mv    = (r_w < n_w) && (rd_b_q > bigv1);
		moved   = l_mv || r_mv;
		big_idx = r_mv ? r_w[IW-1:0] : l_w[IW-1:0];
		big_val = r_mv ? rd_b_q : rd_a_q;
	end

	// Tally increments: one per sift-up compare, two per level on delete, and on build one per child that beats the larger
	always_comb begin
		if (state_q == S_UP_CMP) begin
			cmp_inc = 2'd1;
		end else if (del_mode_q) begin
			cmp_inc = 2'd2;
		end else begin
			cmp_inc = 2'(l_mv) + 2'(r_mv);
		end
		cmp_sum  = {1'b0, cmp_q} + (CMP_W + 1)'(cmp_inc);
		cmp_next = cmp_sum[CMP_W] ? CMP_MAX : cmp_sum[CMP_W-1:0];
		swp_next = (swp_q == SWP_MAX) ? SWP_MAX : swp_q + SWP_W'(1);
	end

	// Store port schedule
	always_comb begin
		we = 1'b0;
		wa = i_q;
		wd = cur_q;
		ra = '0;
		rb = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd == CMD_APPEND && !full) begin
					we = 1'b1;
					wa = cnt_idx;
					wd = s_axis_tdata;
				end
				rb = cnt_idx - IW'(1);
			end
			S_UP_RD: begin
				we = (i_q == '0);
				ra = parent;
			end
			S_UP_CMP: begin
				we = 1'b1;
				wd = (rd_a_q < cur_q) ? rd_a_q : cur_q;
			end
			S_BLD_NEXT: begin
				ra = k_q - IW'(1);
			end
			S_DN_RD: begin
				ra = l_w[IW-1:0];
				rb = r_w[IW-1:0];
			end
			S_DN_CMP: begin
				we = 1'b1;
				wd = moved ? big_val : cur_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			del_mode_q <= 1'b0;
			status_q   <= ST_OK;
			cmp_q      <= '0;
			swp_q      <= '0;
			i_q        <= '0;
			k_q        <= '0;
			cur_q      <= '0;
			res_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmp_q      <= '0;
						swp_q      <= '0;
						res_q      <= '0;
						status_q   <= ST_OK;
						del_mode_q <= (cmd == CMD_DELETE);
						cur_q      <= s_axis_tdata;
						i_q        <= cnt_idx;
						k_q        <= half_cnt[IW-1:0];
						case (cmd)
							CMD_INSERT, CMD_APPEND: begin
								if (full) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									count_q <= count_q + CW'(1);
									state_q <= (cmd == CMD_INSERT) ? S_UP_RD : S_DONE;
								end
							end
							CMD_DELETE: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									count_q <= count_q - CW'(1);
									state_q <= S_DEL_RD;
								end
							end
							default: begin
								state_q <= (half_cnt == '0) ? S_DONE : S_BLD_NEXT;
							end
						endcase
					end
				end
				// Sift up: hole at i, climb while the parent is smaller
				S_UP_RD: begin
					state_q <= (i_q == '0) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					cmp_q <= cmp_next;
					if (rd_a_q < cur_q) begin
						swp_q   <= swp_next;
						i_q     <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				// Take the root as result, last entry becomes the hole value
				S_DEL_RD: begin
					res_q   <= rd_a_q;
					cur_q   <= rd_b_q;
					i_q     <= '0;
					state_q <= S_DN_RD;
				end
				// Next build root, walking down towards zero
				S_BLD_NEXT: begin
					k_q     <= k_q - IW'(1);
					i_q     <= k_q - IW'(1);
					state_q <= S_BLD_RD;
				end
				S_BLD_RD: begin
					cur_q   <= rd_a_q;
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= S_DN_CMP;
				end
				// Sift down: move the larger child up or settle the hole
				S_DN_CMP: begin
					cmp_q <= cmp_next;
					if (moved) begin
						swp_q   <= swp_next;
						i_q     <= big_idx;
						state_q <= S_DN_RD;
					end else if (del_mode_q || k_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_BLD_NEXT;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_data_q   <= OUT_DATA_W'({cnt_ext[CNT_W-1:0], swp_q, cmp_q, res_q});
			out_status_q <= status_q;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

endmodule

// File: hw/rtl/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks of the max-heap priority queue, bound to its top level.
// ----------------------------------------------------------------------------
module mhpq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [mhpq_pkg::VALUE_W-1:0]    s_axis_tdata,
	input logic [mhpq_pkg::CMD_W-1:0]      s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [mhpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [mhpq_pkg::STATUS_W-1:0]   m_axis_tuser
);
	import mhpq_pkg::*;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// One command in flight: no new beat right after one is taken
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command accepted back to back");

	// Delete on an empty heap returns zero value and zero tallies
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_EMPTY
		|-> m_axis_tdata[SWP_LO+SWP_W-1:RES_LO] == '0
		&& m_axis_tdata[CNT_LO+CNT_W-1:CNT_LO] == '0)
		else $error("empty result carries data");

	// A refused insert or append does no work
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_FULL
		|-> m_axis_tdata[SWP_LO+SWP_W-1:RES_LO] == '0)
		else $error("full result carries tallies");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
